// ===== rtl/core/tsic_pkg.sv =====
// Shared types and constants for the triangle subset index compactor.
package tsic_pkg;

  localparam int FACE_PARAM_W = 14;
  localparam int VERT_W       = 16;
  localparam int FACE_DEPTH   = 4096;
  localparam int FACE_AW      = $clog2(FACE_DEPTH);
  localparam int VERT_DEPTH   = 65536;
  localparam int VERT_AW      = $clog2(VERT_DEPTH);
  localparam int ID_W         = VERT_AW + 1;
  localparam int CORNERS      = 3;
  localparam int CORNER_W     = $clog2(CORNERS);

  localparam logic [1:0] KIND_FACE   = 2'd0;
  localparam logic [1:0] KIND_SUBSET = 2'd1;
  localparam logic [1:0] KIND_TRI    = 2'd2;

  typedef struct packed {
    logic [1:0]              kind;
    logic [FACE_PARAM_W-1:0] face_param;
    logic                    member_flag;
    logic [VERT_W-1:0]       corner_a;
    logic [VERT_W-1:0]       corner_b;
    logic [VERT_W-1:0]       corner_c;
  } in_t;

  typedef struct packed {
    logic [VERT_W-1:0] compact_index;
    logic              is_new_vertex;
    logic [VERT_W-1:0] source_vertex;
    logic              last_corner;
  } out_t;

  typedef struct packed {
    logic              start;
    logic              clear;
    logic              wipe;
    logic [VERT_W-1:0] vertex;
  } map_req_t;

  typedef struct packed {
    logic              done;
    logic [VERT_W-1:0] compact_index;
    logic              is_new;
  } map_rsp_t;

endpackage

// ===== rtl/core/triangle_subset_index_compactor.sv =====
// Triangle subset index compactor top level: face filter, corner sequencer, result register.
//
// Face membership and start-of-subset words are taken in the idle state and leave it there. A
// triangle word passes acceptance and the face membership read, then takes each corner
// through the remap table read, the reverse table read, and the compare and allocate step
// of the shared mapper; a stalled result holds the next corner. A triangle on a non-member
// face gives no result. After reset the block clears the face membership RAM and the forward
// remap table, one entry a cycle, before it accepts a word. Starting a new subset costs
// nothing: remap entries are checked against the id counter and a reverse table, so a new
// subset needs no clearing pass.
module triangle_subset_index_compactor (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  tsic_pkg::in_t  item,
  output logic           result_valid,
  input  logic           result_stall,
  output tsic_pkg::out_t result
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FACE,
    ST_START,
    ST_WAIT
  } state_t;

  state_t                            state;
  tsic_pkg::in_t                     word;
  logic [tsic_pkg::CORNER_W-1:0]     corner;
  logic [tsic_pkg::VERT_AW-1:0]      clear_addr;
  logic                              accept;
  logic                              face_we;
  logic [tsic_pkg::FACE_AW-1:0]      face_addr;
  logic                              face_wdata;
  logic                              face_rdata;
  logic                              out_free;
  logic                              last;
  tsic_pkg::map_req_t                req;
  tsic_pkg::map_rsp_t                rsp;

  tsic_ram #(
    .WIDTH (1),
    .DEPTH (tsic_pkg::FACE_DEPTH)
  ) u_face (
    .clk   (clk),
    .we    (face_we),
    .waddr (state == ST_CLEAR ? clear_addr[tsic_pkg::FACE_AW-1:0] : face_addr),
    .wdata (face_wdata),
    .raddr (face_addr),
    .rdata (face_rdata)
  );

  tsic_mapper u_mapper (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always_comb begin
    item_stall = (state != ST_IDLE);
    accept     = item_valid && !item_stall;
    face_addr  = tsic_pkg::FACE_AW'(item.face_param >> 2);
    face_we    = (state == ST_CLEAR) || (accept && item.kind == tsic_pkg::KIND_FACE);
    face_wdata = (state == ST_CLEAR) ? 1'b0 : item.member_flag;
    out_free   = !result_valid || !result_stall;
    last       = (corner == tsic_pkg::CORNER_W'(tsic_pkg::CORNERS - 1));
    req.start  = (state == ST_START) && out_free;
    req.clear  = accept && item.kind == tsic_pkg::KIND_SUBSET;
    req.wipe   = (state == ST_CLEAR);
    if (state == ST_CLEAR) begin
      req.vertex = clear_addr;
    end else begin
      case (corner)
        2'd0:    req.vertex = word.corner_a;
        2'd1:    req.vertex = word.corner_b;
        default: req.vertex = word.corner_c;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clear_addr   <= '0;
      corner       <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clear_addr <= clear_addr + 1'b1;
          if (clear_addr == tsic_pkg::VERT_AW'(tsic_pkg::VERT_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            word   <= item;
            corner <= '0;
            if (item.kind == tsic_pkg::KIND_TRI) begin
              state <= ST_FACE;
            end
          end
        end
        ST_FACE: begin
          state <= face_rdata ? ST_START : ST_IDLE;
        end
        ST_START: begin
          if (out_free) begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (rsp.done) begin
            result_valid         <= 1'b1;
            result.compact_index <= rsp.compact_index;
            result.is_new_vertex <= rsp.is_new;
            result.source_vertex <= req.vertex;
            result.last_corner   <= last;
            if (last) begin
              state <= ST_IDLE;
            end else begin
              corner <= corner + 1'b1;
              state  <= ST_START;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/tsic_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tsic_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/tsic_mapper.sv =====
// Per-corner remap lookup and compact id allocation over a sparse-set table pair.
module tsic_mapper (
  input  logic               clk,
  input  logic               rst,
  input  tsic_pkg::map_req_t req,
  output tsic_pkg::map_rsp_t rsp
);

  typedef enum logic [1:0] {
    M_IDLE,
    M_LOOK,
    M_CHECK
  } state_t;

  state_t                          state;
  logic [tsic_pkg::ID_W-1:0]       count;
  logic [tsic_pkg::VERT_W-1:0]     vertex;
  logic [tsic_pkg::VERT_W-1:0]     fwd_rdata;
  logic [tsic_pkg::VERT_W-1:0]     rev_rdata;
  logic [tsic_pkg::VERT_W-1:0]     id;
  logic                            hit;
  logic                            full;
  logic                            alloc;
  logic                            fwd_we;
  logic [tsic_pkg::VERT_AW-1:0]    fwd_waddr;
  logic [tsic_pkg::VERT_W-1:0]     fwd_wdata;

  tsic_ram #(
    .WIDTH (tsic_pkg::VERT_W),
    .DEPTH (tsic_pkg::VERT_DEPTH)
  ) u_fwd (
    .clk   (clk),
    .we    (fwd_we),
    .waddr (fwd_waddr),
    .wdata (fwd_wdata),
    .raddr (req.vertex),
    .rdata (fwd_rdata)
  );

  tsic_ram #(
    .WIDTH (tsic_pkg::VERT_W),
    .DEPTH (tsic_pkg::VERT_DEPTH)
  ) u_rev (
    .clk   (clk),
    .we    (alloc),
    .waddr (count[tsic_pkg::VERT_AW-1:0]),
    .wdata (vertex),
    .raddr (fwd_rdata),
    .rdata (rev_rdata)
  );

  always_comb begin
    full  = (count == tsic_pkg::ID_W'(tsic_pkg::VERT_DEPTH));
    hit   = ({1'b0, id} < count) && (rev_rdata == vertex);
    alloc = (state == M_CHECK) && !hit && !full;
    fwd_we    = alloc || req.wipe;
    fwd_waddr = req.wipe ? req.vertex : vertex;
    fwd_wdata = req.wipe ? '0 : count[tsic_pkg::VERT_AW-1:0];
    rsp.done = (state == M_CHECK);
    if (hit) begin
      rsp.compact_index = id;
      rsp.is_new        = 1'b0;
    end else if (!full) begin
      rsp.compact_index = count[tsic_pkg::VERT_AW-1:0];
      rsp.is_new        = 1'b1;
    end else begin
      rsp.compact_index = '0;
      rsp.is_new        = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      count <= '0;
    end else begin
      case (state)
        M_IDLE: begin
          if (req.clear) begin
            count <= '0;
          end else if (req.start) begin
            vertex <= req.vertex;
            state  <= M_LOOK;
          end
        end
        M_LOOK: begin
          id    <= fwd_rdata;
          state <= M_CHECK;
        end
        M_CHECK: begin
          if (alloc) begin
            count <= count + 1'b1;
          end
          state <= M_IDLE;
        end
        default: begin
          state <= M_IDLE;
        end
      endcase
    end
  end

endmodule
